// ----- rtl/pun_pkg.sv -----
// Shared types and constants of the PNG scanline unfilter block.
package pun_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int STORE_DEPTH = MAX_WIDTH * 4;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int BIR_W       = $clog2(STORE_DEPTH + 1);
    localparam int WCLAMP_W    = $clog2(MAX_WIDTH + 1);
    localparam int QDEPTH      = 4;

    localparam logic [1:0] REG_WIDTH_PX    = 2'd0;
    localparam logic [1:0] REG_HEIGHT_ROWS = 2'd1;
    localparam logic [1:0] REG_HAS_ALPHA   = 2'd2;

    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

    typedef enum logic [2:0] {
        FILT_NONE    = 3'd0,
        FILT_SUB     = 3'd1,
        FILT_UP      = 3'd2,
        FILT_AVG     = 3'd3,
        FILT_PAETH   = 3'd4,
        FILT_UNKNOWN = 3'd5
    } filt_t;

    typedef struct packed {
        logic [12:0] width_px;
        logic [15:0] height_rows;
        logic        has_alpha;
    } cfg_t;

    typedef struct packed {
        logic [7:0]       data;
        logic [IDX_W-1:0] idx;
        logic [1:0]       lane;
        logic             first_px;
        logic             above;
        logic             last_ch;
        logic             last_byte;
        logic             end_img;
        logic             has_alpha;
        filt_t            filt;
    } ent_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       end_of_row;
        logic       end_of_image;
    } res_t;

endpackage

// ----- rtl/png_scanline_unfilter_rgba.sv -----
// Top level of the PNG scanline unfilter block for 8-bit RGB and RGBA rows.
//
// Input bytes arrive on a queue-style channel: a word is taken when push is
// high and full is low. Each row opens with its filter-type byte, followed by
// width_px times three or four sample bytes. Reconstructed pixels leave on a
// queue-style channel: the oldest pixel is on red, green, blue, alpha,
// end_of_row and end_of_image while empty is low, and pop takes it.
// Configuration words are written on cfg_valid/cfg_ready with cfg_index and
// cfg_data; cfg_ready is always high. Write only while the block is idle.
// One byte is accepted every cycle while full is low. The rate is set by the
// line store, which is read once and written once for each sample byte. A
// pixel reaches the output through the queue, s1_reg and the output buffer.
// When pop stays low, a two-word output buffer and a four-word queue between
// the front and back ends fill in turn, after which full rises.
// Reset returns the registers to one pixel, one row and RGBA, and makes the
// next byte a filter byte of a first row. The line store is not cleared: the
// first row of an image reads zero above, so no clearing pass is needed.
module png_scanline_unfilter_rgba (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic [7:0]  data_byte,
    output logic        full,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [7:0]  alpha,
    output logic        end_of_row,
    output logic        end_of_image,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import pun_pkg::*;

    cfg_t cfg_reg;
    logic q_push, q_full, q_pop, q_empty;
    ent_t q_din, q_head;
    res_t out_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width_px    <= 13'd1;
            cfg_reg.height_rows <= 16'd1;
            cfg_reg.has_alpha   <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_WIDTH_PX:    cfg_reg.width_px    <= cfg_data[12:0];
                REG_HEIGHT_ROWS: cfg_reg.height_rows <= cfg_data;
                REG_HAS_ALPHA:   cfg_reg.has_alpha   <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    pun_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .push      (push),
        .data_byte (data_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_din     (q_din)
    );

    pun_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_head),
        .empty (q_empty)
    );

    pun_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_pop   (pop),
        .out_empty (empty),
        .out_res   (out_res)
    );

    assign full         = q_full;
    assign red          = out_res.red;
    assign green        = out_res.green;
    assign blue         = out_res.blue;
    assign alpha        = out_res.alpha;
    assign end_of_row   = out_res.end_of_row;
    assign end_of_image = out_res.end_of_image;

endmodule

// ----- rtl/pun_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pun_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/pun_front.sv -----
// Front end: accepts bytes, tracks row position and classifies each sample.
module pun_front (
    input  logic          clk,
    input  logic          rst_n,
    input  pun_pkg::cfg_t cfg,
    input  logic          push,
    input  logic [7:0]    data_byte,
    input  logic          q_full,
    output logic          q_push,
    output pun_pkg::ent_t q_din
);
    import pun_pkg::*;

    logic [BIR_W-1:0]    bir_reg, bir_next;
    logic [15:0]         row_reg, row_next;
    logic [1:0]          mod3_reg, mod3_next;
    filt_t               filt_reg, filt_next;

    logic                accept;
    logic [WCLAMP_W-1:0] w;
    logic [15:0]         h;
    logic [BIR_W-1:0]    rowlen;
    logic [BIR_W-1:0]    i;
    logic [BIR_W-1:0]    bpp;
    logic [1:0]          lane;
    logic                last_byte;
    logic                row_last;
    filt_t               filt_dec;

    assign accept = push && !q_full;

    always_comb
    begin
        if (cfg.width_px == 13'd0)
        begin
            w = WCLAMP_W'(1);
        end
        else if (32'(cfg.width_px) > 32'(MAX_WIDTH))
        begin
            w = WCLAMP_W'(MAX_WIDTH);
        end
        else
        begin
            w = WCLAMP_W'(cfg.width_px);
        end
        h      = (cfg.height_rows == 16'd0) ? 16'd1 : cfg.height_rows;
        rowlen = cfg.has_alpha ? (BIR_W'(w) << 2) : (BIR_W'(w) + (BIR_W'(w) << 1));
        bpp    = cfg.has_alpha ? BIR_W'(4) : BIR_W'(3);
        i      = bir_reg - BIR_W'(1);
        lane   = cfg.has_alpha ? i[1:0] : mod3_reg;
        last_byte = bir_reg >= rowlen;
        row_last  = (17'(row_reg) + 17'd1) >= 17'(h);
        filt_dec  = (data_byte <= 8'd4) ? filt_t'(data_byte[2:0]) : FILT_UNKNOWN;
    end

    always_comb
    begin
        q_din.data      = data_byte;
        q_din.idx       = i[IDX_W-1:0];
        q_din.lane      = lane;
        q_din.first_px  = i < bpp;
        q_din.above     = row_reg != 16'd0;
        q_din.last_ch   = lane == (cfg.has_alpha ? 2'd3 : 2'd2);
        q_din.last_byte = last_byte;
        q_din.end_img   = last_byte && row_last;
        q_din.has_alpha = cfg.has_alpha;
        q_din.filt      = filt_reg;
        q_push          = accept && (bir_reg != '0);
    end

    always_comb
    begin
        bir_next  = bir_reg;
        row_next  = row_reg;
        mod3_next = mod3_reg;
        filt_next = filt_reg;
        if (accept)
        begin
            if (bir_reg == '0)
            begin
                filt_next = filt_dec;
                bir_next  = BIR_W'(1);
                mod3_next = 2'd0;
            end
            else
            begin
                bir_next  = last_byte ? '0 : bir_reg + BIR_W'(1);
                mod3_next = (mod3_reg == 2'd2) ? 2'd0 : mod3_reg + 2'd1;
                if (last_byte)
                begin
                    row_next = row_last ? 16'd0 : row_reg + 16'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bir_reg  <= '0;
            row_reg  <= '0;
            mod3_reg <= 2'd0;
            filt_reg <= FILT_NONE;
        end
        else
        begin
            bir_reg  <= bir_next;
            row_reg  <= row_next;
            mod3_reg <= mod3_next;
            filt_reg <= filt_next;
        end
    end

    a_row_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        q_push && last_byte |=> bir_reg == '0)
        else $error("row position not cleared after the last byte of a row");

    a_mod3_range: assert property (@(posedge clk) disable iff (!rst_n)
        mod3_reg != 2'd3)
        else $error("modulo-three lane counter out of range");

endmodule

// ----- rtl/pun_queue.sv -----
// Short queue of classified samples between the front and back ends.
module pun_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  pun_pkg::ent_t din,
    output logic          full,
    input  logic          pop,
    output pun_pkg::ent_t dout,
    output logic          empty
);
    import pun_pkg::*;

    localparam int QAW = $clog2(QDEPTH);
    localparam int QCW = $clog2(QDEPTH + 1);

    ent_t           slot_reg [QDEPTH];
    logic [QAW-1:0] wptr_reg, rptr_reg;
    logic [QCW-1:0] cnt_reg, cnt_next;
    logic           do_push, do_pop;

    assign full    = cnt_reg == QCW'(QDEPTH);
    assign empty   = cnt_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = slot_reg[rptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + QCW'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - QCW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= (32'(wptr_reg) == QDEPTH - 1) ? '0 : wptr_reg + QAW'(1);
            end
            if (do_pop)
            begin
                rptr_reg <= (32'(rptr_reg) == QDEPTH - 1) ? '0 : rptr_reg + QAW'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    a_queue_count: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) <= QDEPTH)
        else $error("queue occupancy exceeds its depth");

endmodule

// ----- rtl/pun_back.sv -----
// Back end: line store access, filter reconstruction and pixel output buffer.
module pun_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  pun_pkg::ent_t q_head,
    output logic          q_pop,
    input  logic          out_pop,
    output logic          out_empty,
    output pun_pkg::res_t out_res
);
    import pun_pkg::*;

    logic       s1_valid_reg;
    ent_t       s1_reg;
    logic [7:0] left_reg [4];
    logic [7:0] ul_reg [4];
    logic [7:0] asm_reg [3];
    res_t       obuf_reg [2];
    logic       owptr_reg, orptr_reg;
    logic [1:0] ocnt_reg, ocnt_next;

    logic [7:0] ram_dout;
    logic       s1_adv, s1_load;
    logic       obuf_push, obuf_pop;
    logic [7:0] a, b, c, r;
    logic [8:0] ab_sum;
    logic [7:0] asm_new [3];
    res_t       res_new;

    function automatic logic [7:0] paeth(input logic [7:0] pa_a, input logic [7:0] pa_b,
                                         input logic [7:0] pa_c);
        logic [8:0] pa, pb, pc, s, c2;
        logic [7:0] sel;
        pa = (pa_b > pa_c) ? 9'(pa_b - pa_c) : 9'(pa_c - pa_b);
        pb = (pa_a > pa_c) ? 9'(pa_a - pa_c) : 9'(pa_c - pa_a);
        s  = 9'(pa_a) + 9'(pa_b);
        c2 = {pa_c, 1'b0};
        pc = (s > c2) ? s - c2 : c2 - s;
        if (pa <= pb && pa <= pc)
        begin
            sel = pa_a;
        end
        else if (pb <= pc)
        begin
            sel = pa_b;
        end
        else
        begin
            sel = pa_c;
        end
        return sel;
    endfunction

    pun_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (s1_reg.idx),
        .wr_data (r),
        .rd_en   (q_pop),
        .rd_addr (q_head.idx),
        .rd_data (ram_dout)
    );

    assign out_empty = ocnt_reg == 2'd0;
    assign obuf_pop  = out_pop && !out_empty;
    assign out_res   = obuf_reg[orptr_reg];

    assign s1_adv    = s1_valid_reg && (!s1_reg.last_ch || ocnt_reg != 2'd2);
    assign s1_load   = !s1_valid_reg || s1_adv;
    assign q_pop     = !q_empty && s1_load;
    assign obuf_push = s1_adv && s1_reg.last_ch;

    always_comb
    begin
        a = s1_reg.first_px ? 8'd0 : left_reg[s1_reg.lane];
        b = s1_reg.above ? ram_dout : 8'd0;
        c = (s1_reg.above && !s1_reg.first_px) ? ul_reg[s1_reg.lane] : 8'd0;
        ab_sum = 9'(a) + 9'(b);
        unique case (s1_reg.filt)
            FILT_SUB:   r = s1_reg.data + a;
            FILT_UP:    r = s1_reg.data + b;
            FILT_AVG:   r = s1_reg.data + ab_sum[8:1];
            FILT_PAETH: r = s1_reg.data + paeth(a, b, c);
            default:    r = s1_reg.data;
        endcase
        for (int n = 0; n < 3; n++)
        begin
            asm_new[n] = (32'(s1_reg.lane) == n) ? r : asm_reg[n];
        end
        res_new.red          = asm_new[0];
        res_new.green        = asm_new[1];
        res_new.blue         = asm_new[2];
        res_new.alpha        = s1_reg.has_alpha ? r : ALPHA_OPAQUE;
        res_new.end_of_row   = s1_reg.last_byte;
        res_new.end_of_image = s1_reg.end_img;
    end

    always_comb
    begin
        ocnt_next = ocnt_reg;
        if (obuf_push && !obuf_pop)
        begin
            ocnt_next = ocnt_reg + 2'd1;
        end
        else if (obuf_pop && !obuf_push)
        begin
            ocnt_next = ocnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_reg <= q_head;
        end
        if (obuf_push)
        begin
            obuf_reg[owptr_reg] <= res_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            owptr_reg    <= 1'b0;
            orptr_reg    <= 1'b0;
            ocnt_reg     <= 2'd0;
            for (int n = 0; n < 4; n++)
            begin
                left_reg[n] <= 8'd0;
                ul_reg[n]   <= 8'd0;
            end
            for (int n = 0; n < 3; n++)
            begin
                asm_reg[n] <= 8'd0;
            end
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= !q_empty;
            end
            if (s1_adv)
            begin
                left_reg[s1_reg.lane] <= r;
                ul_reg[s1_reg.lane]   <= b;
                for (int n = 0; n < 3; n++)
                begin
                    asm_reg[n] <= asm_new[n];
                end
            end
            if (obuf_push)
            begin
                owptr_reg <= !owptr_reg;
            end
            if (obuf_pop)
            begin
                orptr_reg <= !orptr_reg;
            end
            ocnt_reg <= ocnt_next;
        end
    end

    a_obuf_count: assert property (@(posedge clk) disable iff (!rst_n)
        ocnt_reg <= 2'd2)
        else $error("output buffer occupancy exceeds two");

    a_obuf_grows: assert property (@(posedge clk) disable iff (!rst_n)
        obuf_push && !obuf_pop |=> ocnt_reg == $past(ocnt_reg) + 2'd1)
        else $error("completed pixel not held in the output buffer");

endmodule
